// ----- design/greedy_nonoverlap_region_filter_defines.svh -----
// assertion macros shared by the region filter rtl
`ifndef GREEDY_NONOVERLAP_REGION_FILTER_DEFINES_SVH
`define GREEDY_NONOVERLAP_REGION_FILTER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define GNRF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define GNRF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/gnrf_pkg.sv -----
// types and helper functions of the greedy region filter
`default_nettype none

package gnrf_pkg;

   localparam int POS_W = 32;
   localparam int END_W = 33;
   localparam int LEN_W = 8;
   localparam int CNT_OUT_W = 9;

   // one input transaction
   typedef struct packed {
      logic             start_new_set;
      logic [POS_W-1:0] first_repeat_pos;
      logic [POS_W-1:0] last_repeat_pos;
      logic [LEN_W-1:0] repeat_length;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic                 kept;
      logic                 dropped_full;
      logic [CNT_OUT_W-1:0] kept_count;
   } rsp_type;

   // one stored region
   typedef struct packed {
      logic [POS_W-1:0] span_start;
      logic [END_W-1:0] span_end;
   } span_type;

   localparam int SPAN_W = $bits(span_type);

   // inclusive end: last plus length minus one, zero length counts as one
   function automatic logic [END_W-1:0] span_end_of(input logic [POS_W-1:0] last_pos,
                                                    input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] add;
      add = (len == '0) ? '0 : len - 1'b1;
      return {1'b0, last_pos} + {{(END_W-LEN_W){1'b0}}, add};
   endfunction

   // two inclusive spans share at least one position
   function automatic logic spans_touch(input span_type a, input span_type b);
      logic a_leads;
      logic b_leads;
      a_leads = (a.span_start <= b.span_start) && (a.span_end >= {1'b0, b.span_start});
      b_leads = (b.span_start <= a.span_start) && (b.span_end >= {1'b0, a.span_start});
      return a_leads || b_leads;
   endfunction

endpackage

`default_nettype wire

// ----- design/gnrf_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module gnrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/greedy_nonoverlap_region_filter.sv -----
// Greedy non-overlapping region filter: keeps a region when it overlaps no kept one.
// A transaction is accepted only while idle; the scan of the region table ram reads one
// entry per cycle and stops at the first overlap or after the last kept entry.
// The next transaction waits until the scan of the last one is finished. Results cannot be stalled.
// Reset: synchronous; empties the table (count to zero), ram contents are left as is.
`default_nettype none
`include "greedy_nonoverlap_region_filter_defines.svh"

module greedy_nonoverlap_region_filter
   import gnrf_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   span_type      cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          hit_now;
   logic          finish;
   logic          issue;
   logic          wr_en;
   span_type      rd_span;
   logic [SPAN_W-1:0] rd_word;
   logic [31:0]   cnt_ext;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // table of kept spans; writes only go to entry count, reads only below it
   gnrf_ram #(
      .WIDTH(SPAN_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(cur_ff),
      .rd_en  (issue),
      .rd_addr(rd_idx_ff[AW-1:0]),
      .rd_data(rd_word)
   );

   assign rd_span = span_type'(rd_word);

   // scan control: compare one entry per cycle against the candidate
   assign hit_now = (state_ff == ST_SCAN) && cmp_vld_ff && spans_touch(cur_ff, rd_span);
   assign finish  = (state_ff == ST_SCAN) && (hit_now || (rd_idx_ff == count_ff));
   assign issue   = (state_ff == ST_SCAN) && (rd_idx_ff != count_ff) && !hit_now;
   assign wr_en   = finish && !hit_now && (count_ff != CNT_MAX);

   assign cnt_ext = 32'(count_in);

   // next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in.span_start = req_data.first_repeat_pos;
               cur_in.span_end   = span_end_of(req_data.last_repeat_pos,
                                               req_data.repeat_length);
               if (req_data.start_new_set) begin
                  count_in = '0;
               end
               rd_idx_in = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (finish) begin
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_data_in.kept         = wr_en;
      rsp_data_in.dropped_full = finish && !hit_now && (count_ff == CNT_MAX);
      rsp_data_in.kept_count   = cnt_ext[CNT_OUT_W-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `GNRF_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_MAX, "kept count above table depth")
   `GNRF_ASSERT_IMP(a_rd_below_count, issue, rd_idx_ff < count_ff, "read beyond kept entries")
   `GNRF_ASSERT_IMP(a_no_rw_overlap, wr_en, !issue, "table write during scan read")
   `GNRF_ASSERT_IMP(a_one_flag, rsp_valid_ff, !(rsp_data_ff.kept && rsp_data_ff.dropped_full), "kept and dropped together")
   `GNRF_ASSERT_NXT(a_kept_grows, wr_en, count_ff == $past(count_ff) + 1'b1, "kept without count step")

endmodule

`default_nettype wire
